FILE: hdl/servo_command_stability_filter_macros.svh
// ----------------------------------------------------------------------------
// Servo command stability filter assertion macros
// Shorthand for clocked assertions that are off while reset is held.
// ----------------------------------------------------------------------------
`ifndef SERVO_COMMAND_STABILITY_FILTER_MACROS_SVH
`define SERVO_COMMAND_STABILITY_FILTER_MACROS_SVH

// Checks a property on every rising edge of clk_i outside reset.
`define SCSF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that an antecedent implies a consequent in the next cycle.
`define SCSF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/scsf_pkg.sv
// ----------------------------------------------------------------------------
// Servo command stability filter package
// Shared types, register defaults and the angle to pulse conversion.
// ----------------------------------------------------------------------------
package scsf_pkg;

  localparam int unsigned AngleFields = 6;
  localparam int unsigned MaxChannels = 8;
  localparam int unsigned IdW         = 11;
  localparam int unsigned LenW        = 4;
  localparam int unsigned DegW        = 8;
  localparam int unsigned PulseW      = 12;
  localparam int unsigned CfgIdxW     = 4;
  localparam int unsigned CfgDataW    = 11;

  localparam int unsigned DefChannels = 6;

  localparam logic [DegW-1:0]   MaxDeg    = 8'd180;
  localparam logic [DegW-1:0]   CenterDeg = 8'd90;
  localparam logic [PulseW-1:0] PulseMin  = 12'd500;

  // floor(deg * 2000 / 180) equals (deg * PulseMul) >> PulseShift for deg <= 180.
  localparam int unsigned PulseShift = 16;
  localparam int unsigned PulseMulW  = 20;
  localparam logic [PulseMulW-1:0] PulseMul = 20'd728178;

  localparam logic [IdW-1:0]  DefIdA     = 11'd100;
  localparam logic [IdW-1:0]  DefIdB     = 11'h100;
  localparam logic [DegW-1:0] DefDeadband = 8'd2;
  localparam logic [DegW-1:0] DefRepeats  = 8'd3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegIdA     = 4'd0;
  localparam logic [CfgIdxW-1:0] RegIdB     = 4'd1;
  localparam logic [CfgIdxW-1:0] RegDeadband = 4'd2;
  localparam logic [CfgIdxW-1:0] RegRepeats  = 4'd3;

  typedef struct packed {
    logic [IdW-1:0]  frame_id;
    logic [LenW-1:0] frame_len;
    logic [DegW-1:0] angle_0;
    logic [DegW-1:0] angle_1;
    logic [DegW-1:0] angle_2;
    logic [DegW-1:0] angle_3;
    logic [DegW-1:0] angle_4;
    logic [DegW-1:0] angle_5;
  } cmd_t;

  typedef struct packed {
    logic              frame_accepted;
    logic              any_target_changed;
    logic [PulseW-1:0] pulse_0;
    logic [PulseW-1:0] pulse_1;
    logic [PulseW-1:0] pulse_2;
    logic [PulseW-1:0] pulse_3;
    logic [PulseW-1:0] pulse_4;
    logic [PulseW-1:0] pulse_5;
  } res_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_t;

  typedef struct packed {
    logic [DegW-1:0] deadband;
    logic [DegW-1:0] repeats;
  } lane_cfg_t;

  typedef struct packed {
    logic accepted;
    logic changed;
  } flags_t;

  typedef logic [AngleFields-1:0][DegW-1:0] deg_vec_t;

endpackage

FILE: hdl/scsf_stream_if.sv
// ----------------------------------------------------------------------------
// Servo command stability filter stream interface
// Valid/ready channel with a typed payload, used for every stream port of the block.
// ----------------------------------------------------------------------------
interface scsf_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

FILE: hdl/scsf_lane.sv
// ----------------------------------------------------------------------------
// Servo command stability filter lane
// Candidate, repeat count and target of one channel, updated per frame.
// ----------------------------------------------------------------------------
module scsf_lane (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     upd_i,
  input  logic [scsf_pkg::DegW-1:0] angle_i,
  input  scsf_pkg::lane_cfg_t      cfg_i,
  output logic [scsf_pkg::DegW-1:0] target_o,
  output logic                     changed_o
);

  logic [scsf_pkg::DegW-1:0] cand_q, cand_d;
  logic [scsf_pkg::DegW-1:0] cnt_q, cnt_d;
  logic [scsf_pkg::DegW-1:0] tgt_q, tgt_d;
  logic [scsf_pkg::DegW-1:0] deg;
  logic [scsf_pkg::DegW-1:0] cand_gap;
  logic [scsf_pkg::DegW-1:0] tgt_gap;
  logic                      take;

  assign deg      = (angle_i > scsf_pkg::MaxDeg) ? scsf_pkg::MaxDeg : angle_i;
  assign cand_gap = (cand_q > deg) ? (cand_q - deg) : (deg - cand_q);

  always_comb begin
    cand_d = cand_q;
    cnt_d  = cnt_q;
    if (cand_gap <= cfg_i.deadband) begin
      if (cnt_q < cfg_i.repeats) begin
        cnt_d = cnt_q + 8'd1;
      end
    end else begin
      cand_d = deg;
      cnt_d  = 8'd1;
    end
  end

  assign tgt_gap   = (tgt_q > cand_d) ? (tgt_q - cand_d) : (cand_d - tgt_q);
  assign take      = (cnt_d >= cfg_i.repeats) && (tgt_gap > cfg_i.deadband);
  assign tgt_d     = take ? cand_d : tgt_q;
  assign changed_o = upd_i && take;
  assign target_o  = tgt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q <= scsf_pkg::CenterDeg;
      cnt_q  <= '0;
      tgt_q  <= scsf_pkg::CenterDeg;
    end else if (upd_i) begin
      cand_q <= cand_d;
      cnt_q  <= cnt_d;
      tgt_q  <= tgt_d;
    end
  end

endmodule

FILE: hdl/scsf_merge.sv
// ----------------------------------------------------------------------------
// Servo command stability filter merge stage
// Maps every lane target to a pulse width and registers the result item.
// ----------------------------------------------------------------------------
module scsf_merge (
  input  logic                clk_i,
  input  logic                load_i,
  input  scsf_pkg::flags_t    flags_i,
  input  scsf_pkg::deg_vec_t  targets_i,
  output scsf_pkg::res_t      res_o
);

  localparam int unsigned ProdW = scsf_pkg::DegW + scsf_pkg::PulseMulW;

  logic [scsf_pkg::AngleFields-1:0][scsf_pkg::PulseW-1:0] pulse;
  scsf_pkg::res_t res_q, res_d;

  for (genvar g = 0; g < scsf_pkg::AngleFields; g++) begin : g_pulse
    logic [ProdW-1:0] prod;
    assign prod = ProdW'(targets_i[g]) * ProdW'(scsf_pkg::PulseMul);
    assign pulse[g] = scsf_pkg::PulseMin
                    + prod[scsf_pkg::PulseShift +: scsf_pkg::PulseW];
  end

  always_comb begin
    res_d.frame_accepted     = flags_i.accepted;
    res_d.any_target_changed = flags_i.changed;
    res_d.pulse_0            = pulse[0];
    res_d.pulse_1            = pulse[1];
    res_d.pulse_2            = pulse[2];
    res_d.pulse_3            = pulse[3];
    res_d.pulse_4            = pulse[4];
    res_d.pulse_5            = pulse[5];
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

FILE: hdl/servo_command_stability_filter.sv
// Pipeline: a taken frame's flags pass the first-stage register, then the output
// register. Throughput: one frame per cycle while the output is not stalled; the
// lanes update in the accept cycle and the pulse multipliers sit in the following output stage.
// Reset: candidates and targets go to 90 degrees, repeat counts to zero and
// the registers to their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Servo command stability filter
// Checks command frames, debounces each channel angle and reports pulses.
// ----------------------------------------------------------------------------
`include "servo_command_stability_filter_macros.svh"

module servo_command_stability_filter #(
  parameter int unsigned CHANNELS = scsf_pkg::DefChannels
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  scsf_stream_if.sink   cmd_i,
  scsf_stream_if.source res_o,
  scsf_stream_if.sink   cfg_i
);

  localparam int unsigned NumLanes =
    (CHANNELS > scsf_pkg::AngleFields) ? scsf_pkg::AngleFields : CHANNELS;

  logic [scsf_pkg::IdW-1:0]  id_a_q;
  logic [scsf_pkg::IdW-1:0]  id_b_q;
  logic [scsf_pkg::DegW-1:0] deadband_q;
  logic [scsf_pkg::DegW-1:0] repeats_q;

  scsf_pkg::cmd_t     cmd;
  scsf_pkg::cfg_t     cfg;
  scsf_pkg::lane_cfg_t lane_cfg;
  scsf_pkg::deg_vec_t angles;
  scsf_pkg::deg_vec_t targets;
  scsf_pkg::flags_t   s1_q, s1_d;
  scsf_pkg::res_t     res;
  logic [scsf_pkg::AngleFields-1:0] lane_chg;

  logic in_fire;
  logic frame_ok;
  logic s1_valid_q;
  logic out_valid_q;
  logic s1_move;

  assign cmd = cmd_i.payload;
  assign cfg = cfg_i.payload;

  // Configuration registers; unknown indexes are dropped.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_a_q     <= scsf_pkg::DefIdA;
      id_b_q     <= scsf_pkg::DefIdB;
      deadband_q <= scsf_pkg::DefDeadband;
      repeats_q  <= scsf_pkg::DefRepeats;
    end else if (cfg_i.valid) begin
      case (cfg.index)
        scsf_pkg::RegIdA:      id_a_q     <= cfg.data;
        scsf_pkg::RegIdB:      id_b_q     <= cfg.data;
        scsf_pkg::RegDeadband: deadband_q <= cfg.data[scsf_pkg::DegW-1:0];
        scsf_pkg::RegRepeats:  repeats_q  <= cfg.data[scsf_pkg::DegW-1:0];
        default: ;
      endcase
    end
  end

  assign lane_cfg.deadband = deadband_q;
  assign lane_cfg.repeats  = repeats_q;

  // Handshake: the first stage moves on whenever the output register is free.
  assign s1_move     = s1_valid_q && (!out_valid_q || res_o.ready);
  assign cmd_i.ready = !s1_valid_q || s1_move;
  assign in_fire     = cmd_i.valid && cmd_i.ready;

  assign frame_ok = ((cmd.frame_id == id_a_q) || (cmd.frame_id == id_b_q))
                 && (cmd.frame_len >= scsf_pkg::LenW'(CHANNELS));

  assign angles[0] = cmd.angle_0;
  assign angles[1] = cmd.angle_1;
  assign angles[2] = cmd.angle_2;
  assign angles[3] = cmd.angle_3;
  assign angles[4] = cmd.angle_4;
  assign angles[5] = cmd.angle_5;

  for (genvar g = 0; g < scsf_pkg::AngleFields; g++) begin : g_lane
    if (g < NumLanes) begin : g_used
      scsf_lane u_lane (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .upd_i     (in_fire && frame_ok),
        .angle_i   (angles[g]),
        .cfg_i     (lane_cfg),
        .target_o  (targets[g]),
        .changed_o (lane_chg[g])
      );
    end else begin : g_idle
      // Channels without a lane report the center position.
      assign targets[g]  = scsf_pkg::CenterDeg;
      assign lane_chg[g] = 1'b0;
    end
  end

  assign s1_d.accepted = frame_ok;
  assign s1_d.changed  = |lane_chg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= s1_d;
    end
  end

  // The targets still hold this request's outcome while its flags move on.
  scsf_merge u_merge (
    .clk_i     (clk_i),
    .load_i    (s1_move),
    .flags_i   (s1_q),
    .targets_i (targets),
    .res_o     (res)
  );

  assign res_o.valid   = out_valid_q;
  assign res_o.payload = res;

  `SCSF_ASSERT(a_chg_needs_acc, !s1_valid_q || !s1_q.changed || s1_q.accepted, "change flagged on a rejected frame")
  `SCSF_ASSERT_NEXT(a_reject_holds, in_fire && !frame_ok, $stable(targets), "rejected frame moved a target")
  `SCSF_ASSERT(a_out_chg_acc, !out_valid_q || !res.any_target_changed || res.frame_accepted, "result reports change without acceptance")
  `SCSF_ASSERT_NEXT(a_no_fire_holds, !in_fire, $stable(targets), "target moved without an accepted request")

endmodule

FILE: tb/sv/servo_pulse_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo pulse checker
// Watches the command, configuration and result channels of the stability
// filter. It keeps its own copy of the per-channel debounce state and checks
// every result in order against the expected pulse report.
// ----------------------------------------------------------------------------
module servo_pulse_checker
  import scsf_pkg::*;
#(
  parameter int unsigned Channels = DefChannels
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  input  logic        cmd_ready_i,
  input  cmd_t        cmd_i,
  input  logic        res_valid_i,
  input  logic        res_ready_i,
  input  res_t        res_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  cfg_t        cfg_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_o
);

  localparam int unsigned PulseBase = 500;
  localparam int unsigned PulseSpan = 2000;
  localparam int unsigned FullDeg   = 180;

  logic [IdW-1:0]  id_a;
  logic [IdW-1:0]  id_b;
  logic [DegW-1:0] deadband;
  logic [DegW-1:0] repeats;

  logic [DegW-1:0] cand_deg [AngleFields];
  logic [DegW-1:0] hits     [AngleFields];
  logic [DegW-1:0] tgt_deg  [AngleFields];

  res_t        pulses_due [$];
  res_t        want;
  int unsigned err_total;

  function automatic int unsigned deg_gap(input logic [DegW-1:0] a, input logic [DegW-1:0] b);
    return (a > b) ? int'(a - b) : int'(b - a);
  endfunction

  function automatic logic [PulseW-1:0] deg_pulse(input logic [DegW-1:0] d);
    int unsigned w;
    w = PulseBase + (PulseSpan * int'(d)) / FullDeg;
    return w[PulseW-1:0];
  endfunction

  function automatic logic [PulseW-1:0] lane_pulse(input int unsigned ch);
    return (ch < Channels) ? deg_pulse(tgt_deg[ch]) : deg_pulse(CenterDeg);
  endfunction

  // Updates the debounce state for one command frame and returns the report.
  function automatic res_t apply_command(input cmd_t f);
    res_t            r;
    logic [DegW-1:0] ang [AngleFields];
    logic [DegW-1:0] deg;
    logic            hit;
    logic            moved;
    int unsigned     ch;
    ang[0] = f.angle_0;
    ang[1] = f.angle_1;
    ang[2] = f.angle_2;
    ang[3] = f.angle_3;
    ang[4] = f.angle_4;
    ang[5] = f.angle_5;
    hit = (f.frame_id == id_a || f.frame_id == id_b) && (f.frame_len >= Channels);
    moved = 1'b0;
    if (hit) begin
      for (ch = 0; ch < AngleFields && ch < Channels; ch++) begin
        deg = (ang[ch] > MaxDeg) ? MaxDeg : ang[ch];
        if (deg_gap(cand_deg[ch], deg) <= deadband) begin
          if (hits[ch] < repeats) hits[ch] = hits[ch] + 1'b1;
        end else begin
          cand_deg[ch] = deg;
          hits[ch] = 8'd1;
        end
        if (hits[ch] >= repeats && deg_gap(tgt_deg[ch], cand_deg[ch]) > deadband) begin
          tgt_deg[ch] = cand_deg[ch];
          moved = 1'b1;
        end
      end
    end
    r.frame_accepted = hit;
    r.any_target_changed = moved;
    r.pulse_0 = lane_pulse(0);
    r.pulse_1 = lane_pulse(1);
    r.pulse_2 = lane_pulse(2);
    r.pulse_3 = lane_pulse(3);
    r.pulse_4 = lane_pulse(4);
    r.pulse_5 = lane_pulse(5);
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      err_total++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_a = DefIdA;
      id_b = DefIdB;
      deadband = DefDeadband;
      repeats = DefRepeats;
      for (int i = 0; i < AngleFields; i++) begin
        cand_deg[i] = CenterDeg;
        hits[i] = '0;
        tgt_deg[i] = CenterDeg;
      end
      pulses_due.delete();
      err_total = 0;
      pending_o <= 0;
      mismatch_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_i.index)
          RegIdA:      id_a = cfg_i.data[IdW-1:0];
          RegIdB:      id_b = cfg_i.data[IdW-1:0];
          RegDeadband: deadband = cfg_i.data[DegW-1:0];
          RegRepeats:  repeats = cfg_i.data[DegW-1:0];
          default: ;
        endcase
      end
      if (cmd_valid_i && cmd_ready_i) pulses_due.push_back(apply_command(cmd_i));
      if (res_valid_i && res_ready_i) begin
        if (pulses_due.size() == 0) begin
          $error("result request with no command frame outstanding");
          err_total++;
        end else begin
          want = pulses_due.pop_front();
          check_field("frame_accepted", want.frame_accepted, res_i.frame_accepted);
          check_field("any_target_changed", want.any_target_changed,
                      res_i.any_target_changed);
          check_field("pulse_0", want.pulse_0, res_i.pulse_0);
          check_field("pulse_1", want.pulse_1, res_i.pulse_1);
          check_field("pulse_2", want.pulse_2, res_i.pulse_2);
          check_field("pulse_3", want.pulse_3, res_i.pulse_3);
          check_field("pulse_4", want.pulse_4, res_i.pulse_4);
          check_field("pulse_5", want.pulse_5, res_i.pulse_5);
        end
      end
      pending_o <= pulses_due.size();
      mismatch_count_o <= err_total;
    end
  end

endmodule

FILE: tb/sv/servo_command_stability_filter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo command stability filter testbench
// Drives command frames and register settings into the filter with random
// gaps and output stalls, while the pulse checker predicts every report.
// ----------------------------------------------------------------------------
module servo_command_stability_filter_tb;
  import scsf_pkg::*;

  // No register sits behind this index, so a write to it must change nothing.
  localparam logic [CfgIdxW-1:0] RegSpare = 4'd9;
  localparam int unsigned HoldOffCycles = 300;

  logic clk_i = 1'b0;
  logic rst_ni;

  bit          idle_on = 1'b1;
  bit          hold_off_req = 1'b0;
  int unsigned frames_sent = 0;
  int unsigned settings_done = 1;
  int unsigned pending_res;
  int unsigned mismatch_total;

  logic [IdW-1:0]  cur_id_a = DefIdA;
  logic [IdW-1:0]  cur_id_b = DefIdB;
  logic [DegW-1:0] cur_deadband = DefDeadband;
  logic [DegW-1:0] aim_deg [AngleFields];

  scsf_stream_if #(.payload_t(cmd_t)) cmd_if ();
  scsf_stream_if #(.payload_t(res_t)) res_if ();
  scsf_stream_if #(.payload_t(cfg_t)) cfg_if ();

  servo_command_stability_filter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  servo_pulse_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_valid_i      (cmd_if.valid),
    .cmd_ready_i      (cmd_if.ready),
    .cmd_i            (cmd_if.payload),
    .res_valid_i      (res_if.valid),
    .res_ready_i      (res_if.ready),
    .res_i            (res_if.payload),
    .cfg_valid_i      (cfg_if.valid),
    .cfg_ready_i      (cfg_if.ready),
    .cfg_i            (cfg_if.payload),
    .mismatch_count_o (mismatch_total),
    .pending_o        (pending_res)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #4_000_000;
    $display("Run timed out with %0d results outstanding.", pending_res);
    $display("== FAIL ==");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        res_if.ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
        res_if.ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
        res_if.ready <= 1'b1;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  function automatic cmd_t frame6(input logic [IdW-1:0] id, input logic [LenW-1:0] len,
                                  input logic [DegW-1:0] a0, input logic [DegW-1:0] a1,
                                  input logic [DegW-1:0] a2, input logic [DegW-1:0] a3,
                                  input logic [DegW-1:0] a4, input logic [DegW-1:0] a5);
    cmd_t f;
    f.frame_id = id;
    f.frame_len = len;
    f.angle_0 = a0;
    f.angle_1 = a1;
    f.angle_2 = a2;
    f.angle_3 = a3;
    f.angle_4 = a4;
    f.angle_5 = a5;
    return f;
  endfunction

  // Mostly well-formed frames whose angles hover around a per-channel aim,
  // sometimes just outside the deadband, with occasional jumps and noise.
  function automatic cmd_t next_command();
    logic [IdW-1:0]  id;
    logic [LenW-1:0] len;
    logic [DegW-1:0] a [AngleFields];
    int unsigned     roll;
    int              span;
    int              v;
    int              ch;
    roll = $urandom_range(0, 99);
    if (roll < 45) id = cur_id_a;
    else if (roll < 90) id = cur_id_b;
    else id = IdW'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 80) len = LenW'($urandom_range(6, 8));
    else if (roll < 90) len = LenW'($urandom_range(9, 15));
    else len = LenW'($urandom_range(0, 5));
    span = (cur_deadband > 4) ? 4 : int'(cur_deadband);
    for (ch = 0; ch < AngleFields; ch++) begin
      if ($urandom_range(0, 5) == 0) begin
        aim_deg[ch] = ($urandom_range(0, 3) == 0) ? DegW'($urandom)
                                                  : DegW'($urandom_range(0, 180));
      end
      v = int'(aim_deg[ch]) + int'($urandom_range(0, 2 * span + 2)) - span - 1;
      if (v < 0) v = 0;
      else if (v > 255) v = 255;
      a[ch] = DegW'(v);
    end
    return frame6(id, len, a[0], a[1], a[2], a[3], a[4], a[5]);
  endfunction

  task automatic send_frame(input cmd_t f);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.payload <= f;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    frames_sent++;
  endtask

  task automatic run_frames(input int unsigned n);
    repeat (n) send_frame(next_command());
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_t w;
    w.index = idx;
    w.data = val;
    cfg_if.valid <= 1'b1;
    cfg_if.payload <= w;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
  endtask

  // Stops sending, waits for every outstanding report plus the pipeline
  // depth, then loads a new register setting.
  task automatic program_regs(input logic [IdW-1:0] id_a, input logic [IdW-1:0] id_b,
                              input logic [CfgDataW-1:0] db_word,
                              input logic [CfgDataW-1:0] rep_word, input bit poke_spare);
    cmd_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_res != 0);
    repeat (4) @(posedge clk_i);
    write_reg(RegIdA, CfgDataW'(id_a));
    write_reg(RegIdB, CfgDataW'(id_b));
    write_reg(RegDeadband, db_word);
    write_reg(RegRepeats, rep_word);
    if (poke_spare) write_reg(RegSpare, CfgDataW'($urandom));
    cfg_if.valid <= 1'b0;
    cur_id_a = id_a;
    cur_id_b = id_b;
    cur_deadband = db_word[DegW-1:0];
    settings_done++;
  endtask

  initial begin
    cmd_if.valid <= 1'b0;
    cmd_if.payload <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.payload <= '0;
    for (int i = 0; i < AngleFields; i++) aim_deg[i] = CenterDeg;
    @(posedge rst_ni);
    @(posedge clk_i);

    // Directed frames under the reset setting.
    send_frame(frame6(DefIdA, 4'd6, 8'd90, 8'd90, 8'd90, 8'd90, 8'd90, 8'd90));
    repeat (3) send_frame(frame6(DefIdB, 4'd8, 8'd0, 8'd180, 8'd255, 8'd181, 8'd45, 8'd135));
    send_frame(frame6(DefIdA, 4'd5, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    send_frame(frame6(11'd101, 4'd8, 8'd10, 8'd20, 8'd30, 8'd40, 8'd50, 8'd60));
    send_frame(frame6(11'd2047, 4'd15, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
    send_frame(frame6(11'd0, 4'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    repeat (3) send_frame(frame6(DefIdA, 4'd15, 8'd1, 8'd179, 8'd180, 8'd180, 8'd44, 8'd136));
    repeat (3) send_frame(frame6(DefIdB, 4'd6, 8'd3, 8'd177, 8'd170, 8'd100, 8'd48, 8'd132));
    send_frame(frame6(DefIdA, 4'd9, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
    send_frame(frame6(DefIdB, 4'd7, 8'd2, 8'd178, 8'd172, 8'd98, 8'd50, 8'd130));

    // The result side stalls for a long stretch while frames keep coming.
    hold_off_req = 1'b1;
    run_frames(300);

    program_regs(11'd0, 11'd2047, 11'd0, 11'd1, 1'b0);
    run_frames(300);
    // Deadband at the top of the angle range and the repeat count at its top, with upper data bits set.
    program_regs(11'h555, 11'h2AA, 11'h0B4, 11'h7FF, 1'b0);
    run_frames(250);
    program_regs(DefIdA, DefIdB, 11'd3, 11'd0, 1'b0);
    run_frames(250);
    // Deadband above the angle range, and a write to an unused index.
    program_regs(11'h2AA, 11'h555, 11'h6C8, 11'd2, 1'b1);
    run_frames(200);
    program_regs(IdW'($urandom), IdW'($urandom), CfgDataW'($urandom_range(0, 10)),
                 CfgDataW'($urandom_range(1, 6)), 1'b0);
    run_frames(300);
    program_regs(DefIdA, DefIdB, CfgDataW'(DefDeadband), CfgDataW'(DefRepeats), 1'b0);
    idle_on = 1'b0;
    run_frames(250);

    cmd_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_res != 0);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d command frames across %0d register settings,", frames_sent,
             settings_done);
    $display("with random gaps, output stalls and one %0d-cycle hold-off.", HoldOffCycles);
    if (mismatch_total == 0 && pending_res == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
